[src/iir_direct_form_one_filter_unit_macros.svh]
// assertion macros for the biquad filter unit checker
// depends on nothing; taken in by the checker with an include
`ifndef IIR_DIRECT_FORM_ONE_FILTER_UNIT_MACROS_SVH
`define IIR_DIRECT_FORM_ONE_FILTER_UNIT_MACROS_SVH

// same-cycle implication, quiet while reset is asserted
`define IIRDF1_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, quiet while reset is asserted
`define IIRDF1_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/iirdf1_pkg.sv]
// shared types and constants of the biquad filter unit
// no dependencies; imported by the sequencer, the mac unit, the top level and the testbench
`default_nettype none

package iirdf1_pkg;

    localparam int COEF_W    = 18;
    localparam int COEF_FRAC = 14;
    localparam int RND_SHIFT = 2 * COEF_FRAC;
    localparam int REG_IDX_W = 3;
    localparam int TAP_SLOTS = 8;
    localparam int TAP_IDX_W = 3;

    localparam logic signed [COEF_W-1:0] COEF_ONE = COEF_W'(1 << COEF_FRAC);

    typedef enum logic [REG_IDX_W-1:0] {
        REG_B0,
        REG_B1,
        REG_B2,
        REG_A0,
        REG_A1,
        REG_A2
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_SPLIT,
        ST_SCALE,
        ST_ROUND,
        ST_SAT
    } seq_state_t;

    typedef enum logic [2:0] {
        ACC_HOLD,
        ACC_CLEAR,
        ACC_ADD,
        ACC_SUB,
        ACC_HORNER,
        ACC_ROUND
    } acc_op_t;

    typedef struct packed {
        logic                 idle;
        acc_op_t              acc_op;
        logic                 src_limb;
        logic                 limb_top;
        logic [TAP_IDX_W-1:0] tap_sel;
        logic                 limb_load;
        logic                 limb_shift;
        logic                 round;
        logic                 finish;
    } seq_ctrl_t;

endpackage

`default_nettype wire

[src/iirdf1_mac.sv]
// shared multiply-accumulate unit: registered multiplier feeding one wide adder
// depends on iirdf1_pkg for the accumulator operations and rounding shift
`default_nettype none

module iirdf1_mac
    import iirdf1_pkg::*;
#(
    parameter int OPB_W = 17,
    parameter int ACC_W = 67,
    parameter int SHIFT = 16
) (
    input  wire logic                     aclk,
    input  wire acc_op_t                  acc_op,
    input  wire logic signed [COEF_W-1:0] opa,
    input  wire logic signed [OPB_W-1:0]  opb,
    output      logic        [ACC_W-1:0]  acc
);

    localparam int PRW = COEF_W + OPB_W;
    localparam logic [ACC_W-1:0] RND_POS = ACC_W'(1) << (RND_SHIFT - 1);
    localparam logic [ACC_W-1:0] RND_NEG = RND_POS + ACC_W'(1);

    logic signed [PRW-1:0] prod_reg;
    logic [ACC_W-1:0]      prod_ext;
    logic [ACC_W-1:0]      acc_reg;
    logic [ACC_W-1:0]      acc_next;

    assign prod_ext = {{(ACC_W-PRW){prod_reg[PRW-1]}}, prod_reg};

    always_comb begin
        unique case (acc_op)
            ACC_HOLD:   acc_next = acc_reg;
            ACC_CLEAR:  acc_next = '0;
            ACC_ADD:    acc_next = acc_reg + prod_ext;
            ACC_SUB:    acc_next = acc_reg - prod_ext;
            ACC_HORNER: acc_next = (acc_reg << SHIFT) + prod_ext;
            // magnitude plus half an lsb of the result
            ACC_ROUND:  acc_next = acc_reg[ACC_W-1] ? (~acc_reg + RND_NEG)
                                                    : (acc_reg + RND_POS);
            default:    acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        prod_reg <= opa * opb;
        acc_reg  <= acc_next;
    end

    assign acc = acc_reg;

endmodule

`default_nettype wire

[src/iirdf1_seq.sv]
// step sequencer: walks the taps, the scale limbs, rounding and saturation
// depends on iirdf1_pkg for the state and control types
`default_nettype none

module iirdf1_seq
    import iirdf1_pkg::*;
#(
    parameter int NUM_TAPS  = 5,
    parameter int NUM_LIMBS = 3
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic start,
    input  wire logic start_clear,
    input  wire logic out_free,
    output      seq_ctrl_t ctrl
);

    localparam int CNT_MAX = (NUM_TAPS > NUM_LIMBS) ? NUM_TAPS : NUM_LIMBS;
    localparam int CNT_W   = $clog2(CNT_MAX + 1);

    seq_state_t       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] tap_prev;

    assign tap_prev = cnt_reg - CNT_W'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    cnt_next   = '0;
                    state_next = start_clear ? ST_SAT : ST_MAC;
                end
            end
            ST_MAC: begin
                if (cnt_reg == CNT_W'(NUM_TAPS)) begin
                    cnt_next   = '0;
                    state_next = ST_SPLIT;
                end else begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_SPLIT: begin
                cnt_next   = '0;
                state_next = ST_SCALE;
            end
            ST_SCALE: begin
                if (cnt_reg == CNT_W'(NUM_LIMBS)) begin
                    cnt_next   = '0;
                    state_next = ST_ROUND;
                end else begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_ROUND: state_next = ST_SAT;
            ST_SAT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        ctrl = '{idle: 1'b0, acc_op: ACC_HOLD, src_limb: 1'b0, limb_top: 1'b0,
                 tap_sel: '0, limb_load: 1'b0, limb_shift: 1'b0, round: 1'b0,
                 finish: 1'b0};
        unique case (state_reg)
            ST_IDLE: ctrl.idle = 1'b1;
            ST_MAC: begin
                ctrl.tap_sel = TAP_IDX_W'(cnt_reg);
                // product of the previous tap lands now; feedback taps subtract
                if (cnt_reg == '0) begin
                    ctrl.acc_op = ACC_CLEAR;
                end else if (tap_prev == '0 || tap_prev[0]) begin
                    ctrl.acc_op = ACC_ADD;
                end else begin
                    ctrl.acc_op = ACC_SUB;
                end
            end
            ST_SPLIT: begin
                ctrl.limb_load = 1'b1;
                ctrl.acc_op    = ACC_CLEAR;
            end
            ST_SCALE: begin
                ctrl.src_limb   = 1'b1;
                ctrl.limb_top   = (cnt_reg == '0);
                ctrl.limb_shift = (cnt_reg < CNT_W'(NUM_LIMBS));
                ctrl.acc_op     = (cnt_reg == '0) ? ACC_HOLD : ACC_HORNER;
            end
            ST_ROUND: begin
                ctrl.acc_op = ACC_ROUND;
                ctrl.round  = 1'b1;
            end
            ST_SAT: ctrl.finish = out_free;
            default: ctrl.idle = 1'b0;
        endcase
    end

endmodule

`default_nettype wire

[src/iir_direct_form_one_filter_unit.sv]
// top level of the direct form one biquad filter unit
// depends on iirdf1_pkg, iirdf1_seq and iirdf1_mac
//
// usage
//   s_ channel: one request per sample. s_tuser is the command (0 filter the
//   sample in s_tdata, 1 clear both histories). the unit takes a request only
//   when s_tready is high, and drops s_tready until that request is finished.
//   m_ channel: one result per request, the rounded and saturated output in
//   m_tdata (zero for a clear). the result sits in an output register, so a
//   stalled receiver only holds the unit in its last step; the result stays
//   put until m_tready takes it.
//   cfg channel: cfg_ready is always high; indexes 0..5 write b0, b1, b2, a0,
//   a1, a2 (signed q4.14), other indexes are ignored. write only while idle.
// operation
//   a filter request runs the taps, the scale limbs, rounding and saturation
//   before its result is valid, and s_tready comes back in the same cycle as
//   the result. the unit steps its one shared multiplier over 2*min(order,2)+1
//   taps and then over the limbs of the sum for the final a0 scale. a clear
//   skips the taps and the scale and goes straight to the saturation step.
//   reset gives pass-through coefficients and zero histories.
`default_nettype none

module iir_direct_form_one_filter_unit
    import iirdf1_pkg::*;
#(
    parameter int ORDER        = 2,
    parameter int SAMPLE_WIDTH = 16
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // input request channel
    input  wire logic                           s_tvalid,
    output      logic                           s_tready,
    input  wire logic [((SAMPLE_WIDTH+7)/8)*8-1:0] s_tdata,  // sample
    input  wire logic                           s_tuser,  // command
    // result channel
    output      logic                           m_tvalid,
    input  wire logic                           m_tready,
    output      logic [((SAMPLE_WIDTH+7)/8)*8-1:0] m_tdata,  // filtered
    // coefficient write channel
    input  wire logic                           cfg_valid,
    output      logic                           cfg_ready,
    input  wire logic [REG_IDX_W-1:0]           cfg_index,
    input  wire logic signed [COEF_W-1:0]       cfg_data
);

    localparam int SW        = SAMPLE_WIDTH;
    localparam int TW        = ((SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int LW        = SW;                        // limb width of the scale step
    localparam int BW        = LW + 1;                    // multiplier operand width
    localparam int SUM_W     = SW + COEF_W + 3;           // exact tap sum
    localparam int NUM_LIMBS = (SUM_W + LW - 1) / LW;
    localparam int PW        = NUM_LIMBS * LW + COEF_W + 1; // accumulator width
    localparam int QW        = PW - RND_SHIFT;
    localparam int USED_K    = (ORDER < 2) ? ORDER : 2;   // third-step taps are zero
    localparam int NUM_TAPS  = 2 * USED_K + 1;

    localparam logic [QW-1:0] Q_MAX =
        {{(QW-SW+1){1'b0}}, {(SW-1){1'b1}}};
    localparam logic [QW-1:0] Q_MIN_MAG = Q_MAX + QW'(1);
    localparam logic signed [SW-1:0] Y_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] Y_MIN = {1'b1, {(SW-1){1'b0}}};

    // coefficient registers
    logic signed [COEF_W-1:0] coef_b0_reg, coef_b1_reg, coef_b2_reg;
    logic signed [COEF_W-1:0] coef_a0_reg, coef_a1_reg, coef_a2_reg;

    // filter state and the request in flight
    logic signed [SW-1:0] x_hist_reg [ORDER];
    logic signed [SW-1:0] y_hist_reg [ORDER];
    logic signed [SW-1:0] sample_reg;
    logic                 cmd_reg;
    logic [NUM_LIMBS*LW-1:0] limb_reg;
    logic                 neg_reg;

    logic                 m_tvalid_reg;
    logic [TW-1:0]        m_tdata_reg;

    seq_ctrl_t            ctrl;
    logic                 s_accept;
    logic                 out_free;

    logic signed [COEF_W-1:0] tap_coef [TAP_SLOTS];
    logic signed [SW-1:0]     tap_data [TAP_SLOTS];
    logic signed [COEF_W-1:0] mul_a;
    logic signed [BW-1:0]     mul_b;
    logic [LW-1:0]            limb_top_bits;
    logic [PW-1:0]            acc;
    logic [QW-1:0]            q;
    logic signed [SW-1:0]     y;

    assign s_tready  = ctrl.idle;
    assign s_accept  = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    iirdf1_seq #(
        .NUM_TAPS  (NUM_TAPS),
        .NUM_LIMBS (NUM_LIMBS)
    ) u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start       (s_accept),
        .start_clear (s_tuser),
        .out_free    (out_free),
        .ctrl        (ctrl)
    );

    // coefficient writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_b0_reg <= COEF_ONE;
            coef_b1_reg <= '0;
            coef_b2_reg <= '0;
            coef_a0_reg <= COEF_ONE;
            coef_a1_reg <= '0;
            coef_a2_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_B0:  coef_b0_reg <= cfg_data;
                REG_B1:  coef_b1_reg <= cfg_data;
                REG_B2:  coef_b2_reg <= cfg_data;
                REG_A0:  coef_a0_reg <= cfg_data;
                REG_A1:  coef_a1_reg <= cfg_data;
                REG_A2:  coef_a2_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // latch the request
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            sample_reg <= s_tdata[SW-1:0];
            cmd_reg    <= s_tuser;
        end
    end

    // tap table: slot 0 is b0*x, odd slots b_k*x[k-1], even slots a_k*y[k-1]
    for (genvar gi = 0; gi < TAP_SLOTS; gi++) begin : g_tap
        localparam int K = (gi + 1) / 2;
        if (gi == 0) begin : g_b0
            assign tap_coef[gi] = coef_b0_reg;
            assign tap_data[gi] = sample_reg;
        end else if (gi < NUM_TAPS && (gi % 2) == 1) begin : g_ff
            assign tap_coef[gi] = (K == 1) ? coef_b1_reg : coef_b2_reg;
            assign tap_data[gi] = x_hist_reg[K-1];
        end else if (gi < NUM_TAPS) begin : g_fb
            assign tap_coef[gi] = (K == 1) ? coef_a1_reg : coef_a2_reg;
            assign tap_data[gi] = y_hist_reg[K-1];
        end else begin : g_none
            assign tap_coef[gi] = '0;
            assign tap_data[gi] = '0;
        end
    end

    // operand select: taps first, then the sum one limb at a time, top limb signed
    assign limb_top_bits = limb_reg[NUM_LIMBS*LW-1 -: LW];

    always_comb begin
        if (ctrl.src_limb) begin
            mul_a = coef_a0_reg;
            mul_b = {ctrl.limb_top & limb_top_bits[LW-1], limb_top_bits};
        end else begin
            mul_a = tap_coef[ctrl.tap_sel];
            mul_b = {tap_data[ctrl.tap_sel][SW-1], tap_data[ctrl.tap_sel]};
        end
    end

    iirdf1_mac #(
        .OPB_W (BW),
        .ACC_W (PW),
        .SHIFT (LW)
    ) u_mac (
        .aclk   (aclk),
        .acc_op (ctrl.acc_op),
        .opa    (mul_a),
        .opb    (mul_b),
        .acc    (acc)
    );

    always_ff @(posedge aclk) begin
        if (ctrl.limb_load) begin
            limb_reg <= acc[NUM_LIMBS*LW-1:0];
        end else if (ctrl.limb_shift) begin
            limb_reg <= limb_reg << LW;
        end
        if (ctrl.round) begin
            neg_reg <= acc[PW-1];
        end
    end

    // after rounding the accumulator holds |sum*a0| + half an lsb
    assign q = acc[PW-1:RND_SHIFT];

    always_comb begin
        priority if (cmd_reg) begin
            y = '0;
        end else if (neg_reg) begin
            y = (q > Q_MIN_MAG) ? Y_MIN : -q[SW-1:0];
        end else begin
            y = (q > Q_MAX) ? Y_MAX : q[SW-1:0];
        end
    end

    // history update when the result is handed to the output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < ORDER; i++) begin
                x_hist_reg[i] <= '0;
                y_hist_reg[i] <= '0;
            end
        end else if (ctrl.finish) begin
            if (cmd_reg) begin
                for (int i = 0; i < ORDER; i++) begin
                    x_hist_reg[i] <= '0;
                    y_hist_reg[i] <= '0;
                end
            end else begin
                for (int i = ORDER - 1; i > 0; i--) begin
                    x_hist_reg[i] <= x_hist_reg[i-1];
                    y_hist_reg[i] <= y_hist_reg[i-1];
                end
                x_hist_reg[0] <= sample_reg;
                y_hist_reg[0] <= y;
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (ctrl.finish) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.finish) begin
            m_tdata_reg <= TW'($unsigned(y));
        end
    end

endmodule

`default_nettype wire

[src/iirdf1_checker.sv]
// port-level checker for the biquad filter unit, bound to the top level
// depends on iir_direct_form_one_filter_unit_macros.svh
`default_nettype none

`include "iir_direct_form_one_filter_unit_macros.svh"

module iirdf1_checker #(
    parameter int SAMPLE_WIDTH = 16
) (
    input wire logic                              aclk,
    input wire logic                              aresetn,
    input wire logic                              s_tvalid,
    input wire logic                              s_tready,
    input wire logic                              m_tvalid,
    input wire logic                              m_tready,
    input wire logic [((SAMPLE_WIDTH+7)/8)*8-1:0] m_tdata
);

    // a stalled result holds
    `IIRDF1_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

    // one request at a time: busy right after an acceptance
    `IIRDF1_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready, "request accepted while busy")

    // a fresh result only comes out of a busy cycle
    `IIRDF1_ASSERT_NOW(a_result_from_busy, aclk, aresetn, $rose(m_tvalid), !$past(s_tready), "result appeared without work")

endmodule

bind iir_direct_form_one_filter_unit iirdf1_checker #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_iirdf1_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

[test/iir_direct_form_one_filter_unit_tb.sv]
// self-checking testbench for the direct form one biquad filter unit
// depends on iirdf1_pkg and iir_direct_form_one_filter_unit, which also needs iirdf1_seq and iirdf1_mac
`default_nettype none

module iir_direct_form_one_filter_unit_tb;
    import iirdf1_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SW          = 16;
    localparam int CLK_PERIOD  = 4;
    localparam int IDLE_LIMIT  = 2000;  // cycles with no handshake at all
    localparam int HOLD_CYCLES = 300;   // long receiver hold-off
    localparam int SETTLE      = 20;    // quiet cycles after the last result

    localparam logic signed [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
    localparam logic signed [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};
    localparam logic signed [SW-1:0]     SMP_MAX  = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0]     SMP_MIN  = {1'b1, {(SW-1){1'b0}}};

    // register indexes past a2 are decoded as nothing
    localparam logic [REG_IDX_W-1:0] IDX_SPARE_LO = 3'd6;
    localparam logic [REG_IDX_W-1:0] IDX_SPARE_HI = 3'd7;

    typedef enum logic {
        CMD_FILTER = 1'b0,
        CMD_CLEAR  = 1'b1
    } filter_cmd_t;

    typedef enum logic {
        RX_ALWAYS,
        RX_RANDOM
    } rx_pattern_t;

    typedef enum int {
        SET_MILD,
        SET_FULL,
        SET_EXTREME
    } coef_style_t;

    // dut signals, all inputs known from time zero
    logic                     aclk      = 1'b0;
    logic                     aresetn   = 1'b0;
    logic                     s_tvalid  = 1'b0;
    logic                     s_tready;
    logic [SW-1:0]            s_tdata   = '0;    // sample
    logic                     s_tuser   = 1'b0;  // command
    logic                     m_tvalid;
    logic                     m_tready  = 1'b0;
    logic [SW-1:0]            m_tdata;           // filtered
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [REG_IDX_W-1:0]     cfg_index = '0;
    logic signed [COEF_W-1:0] cfg_data  = '0;

    // predictor state: coefficient copy and the two histories
    logic signed [COEF_W-1:0] coef_copy [0:5] = '{COEF_ONE, '0, '0, COEF_ONE, '0, '0};
    logic signed [SW-1:0]     x_hist1 = '0;
    logic signed [SW-1:0]     x_hist2 = '0;
    logic signed [SW-1:0]     y_hist1 = '0;
    logic signed [SW-1:0]     y_hist2 = '0;

    // outputs still owed by the unit, oldest first
    logic signed [SW-1:0]     expected_filtered [$];

    int          err_count   = 0;
    int          idle_cycles = 0;

    // receiver pattern controls
    rx_pattern_t rx_mode     = RX_RANDOM;
    int          hold_seq    = 0;
    int          hold_seen   = 0;
    int          hold_left   = 0;
    int          stall_left  = 0;

    iir_direct_form_one_filter_unit #(
        .ORDER        (2),
        .SAMPLE_WIDTH (SW)
    ) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // biquad step: exact q.14 sum, times a0, round half away from zero, clamp
    function automatic logic signed [SW-1:0] filter_step(input filter_cmd_t cmd,
                                                         input logic signed [SW-1:0] x);
        longint          b0, b1, b2, a0, a1, a2, acc, res;
        longint unsigned mag, gain, prod, q, full_scale;
        logic            neg;
        logic signed [SW-1:0] y;
        if (cmd == CMD_CLEAR) begin
            x_hist1 = '0;
            x_hist2 = '0;
            y_hist1 = '0;
            y_hist2 = '0;
            return '0;
        end
        b0 = coef_copy[REG_B0];
        b1 = coef_copy[REG_B1];
        b2 = coef_copy[REG_B2];
        a0 = coef_copy[REG_A0];
        a1 = coef_copy[REG_A1];
        a2 = coef_copy[REG_A2];
        acc = b0 * x + b1 * x_hist1 + b2 * x_hist2 - a1 * y_hist1 - a2 * y_hist2;
        // work on magnitudes so the rounding is symmetric about zero
        neg  = (acc < 0) != (a0 < 0);
        mag  = (acc < 0) ? -acc : acc;
        gain = (a0 < 0) ? -a0 : a0;
        prod = mag * gain;
        q    = prod >> RND_SHIFT;
        if (prod[RND_SHIFT-1])
            q = q + 1;
        full_scale = 64'd1 << (SW - 1);
        if (neg)
            res = (q > full_scale) ? -longint'(full_scale) : -longint'(q);
        else
            res = (q > full_scale - 1) ? longint'(full_scale - 1) : longint'(q);
        y = res[SW-1:0];
        // the clamped value is what goes into the feedback history
        x_hist2 = x_hist1;
        x_hist1 = x;
        y_hist2 = y_hist1;
        y_hist1 = y;
        return y;
    endfunction

    // predict on every accepted request, check every accepted result
    always @(posedge aclk) begin
        logic signed [SW-1:0] want;
        if (aresetn) begin
            if (cfg_valid && cfg_ready && cfg_index <= REG_A2)
                coef_copy[cfg_index] = cfg_data;
            if (s_tvalid && s_tready)
                expected_filtered.push_back(filter_step(filter_cmd_t'(s_tuser), s_tdata));
            if (m_tvalid && m_tready) begin
                if (expected_filtered.size() == 0) begin
                    $error("filtered: result with nothing expected, actual %0d",
                           $signed(m_tdata));
                    err_count++;
                end else begin
                    want = expected_filtered.pop_front();
                    if (m_tdata !== want) begin
                        $error("filtered mismatch: expected %0d, actual %0d",
                               want, $signed(m_tdata));
                        err_count++;
                    end
                end
            end
        end
    end

    // receiver: long hold on request, otherwise ready or a random stall pattern
    always @(posedge aclk) begin
        if (hold_seq != hold_seen) begin
            hold_seen <= hold_seq;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (rx_mode == RX_ALWAYS) begin
            m_tready <= 1'b1;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if ($urandom_range(0, 47) == 0) begin
            stall_left <= $urandom_range(1, 30);
            m_tready   <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    // watchdog: ends the run when nothing moves for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IDLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // one request; valid stays high on return so a following request needs no gap
    task automatic send_item(input filter_cmd_t cmd, input logic signed [SW-1:0] smp);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= smp;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic pause_sender(input int cycles);
        if (cycles > 0) begin
            s_tvalid <= 1'b0;
            repeat (cycles) @(posedge aclk);
        end
    endtask

    // sender stops until every owed result has come back
    task automatic wait_until_drained;
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (expected_filtered.size() != 0);
    endtask

    task automatic write_coef(input logic [REG_IDX_W-1:0] idx,
                              input logic signed [COEF_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    // all six taps, plus junk to the undecoded indexes which must change nothing
    task automatic load_coefs(input logic signed [COEF_W-1:0] b0, b1, b2, a0, a1, a2);
        write_coef(REG_B0, b0);
        write_coef(REG_B1, b1);
        write_coef(REG_B2, b2);
        write_coef(REG_A0, a0);
        write_coef(REG_A1, a1);
        write_coef(REG_A2, a2);
        write_coef(IDX_SPARE_LO, COEF_W'($urandom));
        write_coef(IDX_SPARE_HI, COEF_W'($urandom));
        cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [SW-1:0] pick_sample;
        case ($urandom_range(0, 7))
            0:       return SMP_MAX;
            1:       return SMP_MIN;
            2, 3:    return SW'(int'($urandom_range(0, 2047)) - 1024);
            default: return SW'($urandom);
        endcase
    endfunction

    function automatic logic signed [COEF_W-1:0] pick_coef(input coef_style_t style);
        if (style == SET_FULL)
            return COEF_W'($urandom);
        if (style == SET_EXTREME) begin
            case ($urandom_range(0, 3))
                0:       return COEF_MAX;
                1:       return COEF_MIN;
                2:       return '0;
                default: return COEF_ONE;
            endcase
        end
        // small taps keep the feedback loop stable
        return COEF_W'(int'($urandom_range(0, 8192)) - 4096);
    endfunction

    // bursts of random length; gaps unless the stretch is meant to run back to back
    task automatic run_random_items(input int count, input bit no_gaps);
        int          left;
        int          burst;
        filter_cmd_t cmd;
        left = count;
        while (left > 0) begin
            burst = $urandom_range(1, 12);
            while (burst > 0 && left > 0) begin
                cmd = ($urandom_range(0, 15) == 0) ? CMD_CLEAR : CMD_FILTER;
                send_item(cmd, pick_sample());
                left--;
                burst--;
            end
            if (!no_gaps)
                pause_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20));
        end
    endtask

    // reset taps pass the sample straight through, clear returns zero
    task automatic test_pass_through;
        send_item(CMD_FILTER, '0);
        send_item(CMD_FILTER, SMP_MAX);
        send_item(CMD_FILTER, SMP_MIN);
        send_item(CMD_FILTER, 16'sd1);
        send_item(CMD_FILTER, -16'sd1);
        send_item(CMD_FILTER, 16'sh5555);
        send_item(CMD_FILTER, 16'shAAAA);
        send_item(CMD_CLEAR, 16'sh1234);
        wait_until_drained();
    endtask

    // half-lsb ties, clamping at both rails, negative final scale
    task automatic test_rounding_and_saturation;
        load_coefs(COEF_ONE / 2, '0, '0, COEF_ONE, '0, '0);
        send_item(CMD_FILTER, 16'sd1);
        send_item(CMD_FILTER, -16'sd1);
        send_item(CMD_FILTER, 16'sd3);
        wait_until_drained();
        load_coefs(COEF_MAX, '0, '0, COEF_MAX, '0, '0);
        send_item(CMD_FILTER, SMP_MAX);
        send_item(CMD_FILTER, SMP_MIN);
        wait_until_drained();
        load_coefs(COEF_ONE, '0, '0, COEF_MIN, '0, '0);
        send_item(CMD_FILTER, 16'sd1);
        send_item(CMD_FILTER, SMP_MIN);
        wait_until_drained();
    endtask

    // all five taps active, feedback runs into the rail, then clear wipes history
    task automatic test_feedback_and_clear;
        load_coefs(COEF_ONE, COEF_ONE / 2, -COEF_ONE, COEF_ONE, -COEF_ONE, COEF_ONE / 4);
        send_item(CMD_FILTER, 16'sd20000);
        send_item(CMD_FILTER, 16'sd20000);
        send_item(CMD_FILTER, 16'sd5);
        send_item(CMD_CLEAR, SMP_MAX);
        send_item(CMD_FILTER, 16'sd7);
        send_item(CMD_FILTER, -16'sd3);
        wait_until_drained();
    endtask

    // several coefficient sets, one of them with neither side idling
    task automatic test_random_filtering;
        for (int p = 0; p < 6; p++) begin
            coef_style_t style;
            style = coef_style_t'(p % 3);
            wait_until_drained();
            load_coefs(pick_coef(style), pick_coef(style), pick_coef(style),
                       (style == SET_MILD) ? COEF_ONE : pick_coef(style),
                       pick_coef(style), pick_coef(style));
            rx_mode <= (p == 3) ? RX_ALWAYS : RX_RANDOM;
            run_random_items(100, p == 3);
        end
        wait_until_drained();
        rx_mode <= RX_RANDOM;
    endtask

    // receiver holds off while requests keep coming, so the input backs up
    task automatic test_long_hold;
        load_coefs(pick_coef(SET_MILD), pick_coef(SET_MILD), pick_coef(SET_MILD),
                   COEF_ONE, pick_coef(SET_MILD), pick_coef(SET_MILD));
        rx_mode  <= RX_ALWAYS;
        hold_seq <= hold_seq + 1;
        run_random_items(12, 1'b1);
        wait_until_drained();
        rx_mode <= RX_RANDOM;
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        test_pass_through();
        test_rounding_and_saturation();
        test_feedback_and_clear();
        test_random_filtering();
        test_long_hold();
        wait_until_drained();
        repeat (SETTLE) @(posedge aclk);
        if (err_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire

[filelist.f]
+incdir+src
src/iirdf1_pkg.sv
src/iirdf1_mac.sv
src/iirdf1_seq.sv
src/iir_direct_form_one_filter_unit.sv
src/iirdf1_checker.sv
test/iir_direct_form_one_filter_unit_tb.sv
